// ----- sv/mhpq_pkg.sv -----
// shared constants, codes and types for the min-heap priority queue
package mhpq_pkg;

   localparam int CAPACITY = 64;
   localparam int KEY_W = 32;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int COUNT_W = 7;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic              insert;
      logic              remove;
      logic [KEY_W-1:0]  key;
   } cell_ctl_type;

endpackage

// ----- sv/mhpq_cell.sv -----
// one storage cell of the sorted key chain
module mhpq_cell (
   input  logic                        clock,
   input  mhpq_pkg::cell_ctl_type      ctl,
   input  logic                        valid,
   input  logic [mhpq_pkg::KEY_W-1:0]  left_key,
   input  logic                        left_greater,
   input  logic [mhpq_pkg::KEY_W-1:0]  right_key,
   output logic [mhpq_pkg::KEY_W-1:0]  key,
   output logic                        greater
);

   logic [mhpq_pkg::KEY_W-1:0] key_ff;
   logic [mhpq_pkg::KEY_W-1:0] key_in;

   // empty cells count as holding a key above any other
   assign greater = !valid || ($signed(ctl.key) < $signed(key_ff));
   assign key     = key_ff;

   always_comb begin
      key_in = key_ff;
      if (ctl.insert && greater) begin
         key_in = left_greater ? left_key : ctl.key;
      end else if (ctl.remove) begin
         key_in = right_key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

endmodule

// ----- sv/min_heap_priority_queue.sv -----
// top level of the min-heap priority queue built as a sorted chain of cells
//
// Keys are held in ascending order along a row of cells, the smallest in the
// first cell. On an insert, every cell compares the new key
// with its own, and the cells above the insertion point shift one place up. A
// removal shifts every cell one place down. A request is accepted on any
// cycle with start high (busy stays low), so one item per clock is sustained;
// its result appears with rsp_strobe high for exactly one cycle, on the cycle
// after the accepting edge, and must be captured then since it cannot be held
// off. The compare across all cells of the chain sets the cycle time.
module min_heap_priority_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  mhpq_pkg::opcode_type          req_opcode,
   input  logic signed [31:0]            req_value,
   output logic                          rsp_strobe,
   output logic signed [31:0]            rsp_popped,
   output logic signed [31:0]            rsp_minimum,
   output logic [6:0]                    rsp_count,
   output mhpq_pkg::status_type          rsp_status
);

   localparam int N = mhpq_pkg::CAPACITY;

   logic [mhpq_pkg::CNT_W-1:0]  count_ff, count_in;
   logic                        rsp_strobe_ff;
   logic [31:0]                 rsp_popped_ff, rsp_popped_in;
   logic [31:0]                 rsp_minimum_ff, rsp_minimum_in;
   logic [mhpq_pkg::CNT_W-1:0]  rsp_count_ff;
   mhpq_pkg::status_type        rsp_status_ff, rsp_status_in;

   logic                        accept;
   logic                        full;
   logic                        empty;
   mhpq_pkg::cell_ctl_type      ctl;
   logic [mhpq_pkg::KEY_W-1:0]  key_w [N];
   logic                        greater_w [N];
   logic                        valid_w [N];

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign full   = (count_ff >= mhpq_pkg::CNT_W'(N));
   assign empty  = (count_ff == '0);

   assign ctl.insert = accept && (req_opcode == mhpq_pkg::OP_INSERT) && !full;
   assign ctl.remove = accept && (req_opcode == mhpq_pkg::OP_REMOVE) && !empty;
   assign ctl.key    = req_value;

   genvar i;
   generate
      for (i = 0; i < N; i++) begin : g_cell
         assign valid_w[i] = (count_ff > mhpq_pkg::CNT_W'(i));
         if (i == 0) begin : g_first
            mhpq_cell u_cell (
               .clock        (clock),
               .ctl          (ctl),
               .valid        (valid_w[i]),
               .left_key     (req_value),
               .left_greater (1'b0),
               .right_key    (key_w[i+1]),
               .key          (key_w[i]),
               .greater      (greater_w[i])
            );
         end else if (i == N - 1) begin : g_last
            mhpq_cell u_cell (
               .clock        (clock),
               .ctl          (ctl),
               .valid        (valid_w[i]),
               .left_key     (key_w[i-1]),
               .left_greater (greater_w[i-1]),
               .right_key    (key_w[i]),
               .key          (key_w[i]),
               .greater      (greater_w[i])
            );
         end else begin : g_mid
            mhpq_cell u_cell (
               .clock        (clock),
               .ctl          (ctl),
               .valid        (valid_w[i]),
               .left_key     (key_w[i-1]),
               .left_greater (greater_w[i-1]),
               .right_key    (key_w[i+1]),
               .key          (key_w[i]),
               .greater      (greater_w[i])
            );
         end
      end
   endgenerate

   always_comb begin
      count_in       = count_ff;
      rsp_popped_in  = '0;
      rsp_status_in  = mhpq_pkg::ST_OK;
      rsp_minimum_in = empty ? '0 : key_w[0];
      if (ctl.insert) begin
         count_in       = count_ff + 1'b1;
         rsp_minimum_in = greater_w[0] ? req_value : key_w[0];
      end else if (ctl.remove) begin
         count_in       = count_ff - 1'b1;
         rsp_popped_in  = key_w[0];
         rsp_minimum_in = valid_w[1] ? key_w[1] : '0;
      end else if (req_opcode == mhpq_pkg::OP_INSERT) begin
         rsp_status_in  = mhpq_pkg::ST_FULL;
      end else begin
         rsp_status_in  = mhpq_pkg::ST_EMPTY;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rsp_strobe_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_popped_ff  <= rsp_popped_in;
         rsp_minimum_ff <= rsp_minimum_in;
         rsp_count_ff   <= count_in;
         rsp_status_ff  <= rsp_status_in;
      end
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_popped  = rsp_popped_ff;
   assign rsp_minimum = rsp_minimum_ff;
   assign rsp_count   = mhpq_pkg::COUNT_W'(rsp_count_ff);
   assign rsp_status  = rsp_status_ff;

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// testbench for the min-heap priority queue: directed and random inserts and removals
module tb;
   import mhpq_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam logic signed [31:0] KEY_MAX = 32'sh7fffffff;
   localparam logic signed [31:0] KEY_MIN = 32'sh80000000;

   typedef struct {
      logic signed [31:0] popped;
      logic signed [31:0] minimum;
      logic [6:0]         count;
      status_type         status;
   } queue_result_t;

   logic               clock;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   opcode_type         req_opcode = OP_INSERT;
   logic signed [31:0] req_value = '0;
   logic               rsp_strobe;
   logic signed [31:0] rsp_popped;
   logic signed [31:0] rsp_minimum;
   logic [6:0]         rsp_count;
   status_type         rsp_status;

   logic signed [31:0] heap_keys [CAPACITY];
   int                 held;
   queue_result_t      pending_results [$];
   int                 mismatches;
   int                 cycle_count;
   int                 burst_left;

   min_heap_priority_queue DUT (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_opcode  (req_opcode),
      .req_value   (req_value),
      .rsp_strobe  (rsp_strobe),
      .rsp_popped  (rsp_popped),
      .rsp_minimum (rsp_minimum),
      .rsp_count   (rsp_count),
      .rsp_status  (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic void swap_keys(input int a, input int b);
      logic signed [31:0] t;
      t = heap_keys[a];
      heap_keys[a] = heap_keys[b];
      heap_keys[b] = t;
   endfunction

   function automatic queue_result_t predict_queue_step(input opcode_type op,
                                                        input logic signed [31:0] key);
      queue_result_t r;
      int pos;
      int parent;
      int child;
      r.popped = '0;
      r.status = ST_OK;
      if (op == OP_INSERT) begin
         if (held >= CAPACITY) begin
            r.status = ST_FULL;
         end else begin
            heap_keys[held] = key;
            pos = held;
            held++;
            while (pos > 0) begin
               parent = (pos - 1) / 2;
               if (!(heap_keys[pos] < heap_keys[parent])) break;
               swap_keys(pos, parent);
               pos = parent;
            end
         end
      end else begin
         if (held == 0) begin
            r.status = ST_EMPTY;
         end else begin
            swap_keys(0, held - 1);
            held--;
            pos = 0;
            child = 1;
            while (child < held) begin
               if (child + 1 < held && heap_keys[child + 1] < heap_keys[child])
                  child = child + 1;
               if (!(heap_keys[child] < heap_keys[pos])) break;
               swap_keys(child, pos);
               pos = child;
               child = 2 * pos + 1;
            end
            r.popped = heap_keys[held];
         end
      end
      r.minimum = (held > 0) ? heap_keys[0] : '0;
      r.count = held[6:0];
      return r;
   endfunction

   always @(posedge clock) begin
      queue_result_t want;
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            $error("result transfer with nothing pending");
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_popped !== want.popped) begin
               $error("popped: expected %0d, got %0d", want.popped, rsp_popped);
               mismatches++;
            end
            if (rsp_minimum !== want.minimum) begin
               $error("minimum: expected %0d, got %0d", want.minimum, rsp_minimum);
               mismatches++;
            end
            if (rsp_count !== want.count) begin
               $error("count: expected %0d, got %0d", want.count, rsp_count);
               mismatches++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               mismatches++;
            end
         end
      end
   end

   task automatic send_item(input opcode_type op, input logic signed [31:0] key);
      start <= 1'b1;
      req_opcode <= op;
      req_value <= key;
      do @(posedge clock); while (busy);
      pending_results.push_back(predict_queue_step(op, key));
      burst_left--;
      if (burst_left <= 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
      end
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   function automatic logic signed [31:0] random_key();
      case ($urandom_range(0, 9))
         0: return KEY_MAX;
         1: return KEY_MIN;
         2, 3: return $signed($urandom_range(0, 8)) - 4;
         default: return $signed($urandom);
      endcase
   endfunction

   task automatic random_phase(input int items, input int insert_pct);
      for (int i = 0; i < items; i++) begin
         if ($urandom_range(1, 100) <= insert_pct) send_item(OP_INSERT, random_key());
         else send_item(OP_REMOVE, $signed($urandom));
      end
      wait_idle();
   endtask

   task automatic test_empty_removal();
      send_item(OP_REMOVE, 32'sd0);
      send_item(OP_REMOVE, KEY_MAX);
      wait_idle();
   endtask

   task automatic test_key_extremes();
      send_item(OP_INSERT, 32'sd0);
      send_item(OP_INSERT, KEY_MAX);
      send_item(OP_INSERT, KEY_MIN);
      send_item(OP_INSERT, -32'sd1);
      send_item(OP_INSERT, 32'sd1);
      send_item(OP_INSERT, KEY_MIN);
      send_item(OP_INSERT, 32'sd5);
      send_item(OP_INSERT, 32'sd5);
      repeat (8) send_item(OP_REMOVE, -32'sd1);
      send_item(OP_REMOVE, 32'sd0);
      wait_idle();
   endtask

   // insert-heavy, runs into the full refusal
   task automatic test_fill_to_full();
      random_phase(160, 90);
   endtask

   // removal-heavy, runs into the empty refusal
   task automatic test_drain_to_empty();
      random_phase(160, 10);
   endtask

   task automatic test_mixed_traffic();
      random_phase(200, 55);
   endtask

   task automatic test_duplicate_keys();
      for (int i = 0; i < 150; i++) begin
         if ($urandom_range(0, 1)) send_item(OP_INSERT, $signed($urandom_range(0, 3)) - 2);
         else send_item(OP_REMOVE, '0);
      end
      wait_idle();
   endtask

   initial begin
      held = 0;
      mismatches = 0;
      cycle_count = 0;
      burst_left = 4;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_removal();
      test_key_extremes();
      test_fill_to_full();
      test_drain_to_empty();
      test_mixed_traffic();
      test_duplicate_keys();
      test_drain_to_empty();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
